### hw/rtl/cfsd_pkg.sv
// Shared constants, types and the tanh lookup table for the cross-feedback stereo delay.
package cfsd_pkg;

  localparam int RING_DEPTH      = 32768;
  localparam int SAMPLE_BITS     = 18;
  localparam int TANH_TABLE_BITS = 10;

  localparam int ADDR_W    = $clog2(RING_DEPTH);
  localparam int LEN_W     = $clog2(RING_DEPTH + 1);
  localparam int CFG_LEN_W = 16;
  localparam int CFG_OFF_W = 15;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = CFG_LEN_W;
  localparam int CLEN_W    = (CFG_LEN_W > LEN_W) ? CFG_LEN_W : LEN_W;
  localparam int OFF_CMP_W = (CFG_OFF_W > LEN_W) ? CFG_OFF_W : LEN_W;

  localparam logic [CFG_LEN_W-1:0] RING_LENGTH_RESET      = 16'd31752;
  localparam logic [CFG_OFF_W-1:0] LEFT_TAP_OFFSET_RESET  = 15'd13671;
  localparam logic [CFG_OFF_W-1:0] RIGHT_TAP_OFFSET_RESET = 15'd18963;

  localparam int OUT_W      = 16;
  localparam int IN_DATA_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((2 * OUT_W + 7) / 8) * 8;

  // tap gains in Q16, rounded product shifted back down
  localparam int GAIN_W     = 14;
  localparam int GAIN_SHIFT = 16;
  localparam int PROD_W     = SAMPLE_BITS + GAIN_W + 1;
  localparam logic signed [GAIN_W-1:0] GAIN_OUT = 14'sd5243;
  localparam logic signed [GAIN_W-1:0] GAIN_FB  = 14'sd7864;
  localparam logic signed [PROD_W-1:0] GAIN_ROUND = PROD_W'(1 << (GAIN_SHIFT - 1));

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // tanh table spans magnitudes 0 .. 8.0 in Q3.15
  localparam int TAB_N         = 1 << TANH_TABLE_BITS;
  localparam int TAB_SPAN_BITS = 18;
  localparam int TAB_SPAN      = 1 << TAB_SPAN_BITS;
  localparam int TAB_SH        = TAB_SPAN_BITS - TANH_TABLE_BITS;
  localparam int TAB_HALF      = 1 << (TAB_SH - 1);
  localparam int TAB_IDX_W     = $clog2(TAB_N + 1);
  localparam int ABS_W         = (SAMPLE_BITS > TAB_SPAN_BITS) ? SAMPLE_BITS : TAB_SPAN_BITS;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
  localparam int IN_FLIGHT  = 3;

  localparam longint unsigned Q30 = 64'd1 << 30;

  // exp step 2*0.92*8/N in Q30
  localparam longint unsigned TAB_Z =
      ((64'd1472 << 30) + 64'd50 * 64'(TAB_N)) / (64'd100 * 64'(TAB_N));

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RING_LENGTH,
    REG_LEFT_TAP_OFFSET,
    REG_RIGHT_TAP_OFFSET
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_LEN_W-1:0] ring_length;
    logic [CFG_OFF_W-1:0] left_tap_offset;
    logic [CFG_OFF_W-1:0] right_tap_offset;
  } ring_cfg_t;

  typedef struct packed {
    logic                          valid;
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
  } mix_t;

  typedef struct packed {
    logic [OUT_W-1:0] right;
    logic [OUT_W-1:0] left;
  } wet_t;

  typedef logic [TAB_N:0][OUT_W-1:0] tanh_tab_t;

  // shift-subtract quotient, used only while building the table
  function automatic longint unsigned udiv64(input longint unsigned n,
                                             input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      q = {q[62:0], 1'b0};
      if (r >= d) begin
        r = r - d;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // tanh(0.92*8*i/N) = (1-D)/(1+D), D = exp(-2*0.92*8*i/N), series for exp step
  function automatic tanh_tab_t build_tanh_tab();
    tanh_tab_t         tab;
    longint unsigned   z;
    longint unsigned   term;
    longint unsigned   e;
    longint unsigned   d;
    longint unsigned   num;
    longint unsigned   v;
    z = TAB_Z;
    term = Q30;
    e = Q30;
    d = Q30;
    for (int k = 1; k <= 12; k++) begin
      term = udiv64((term * z) >> 30, 64'(k));
      if (k[0]) e = e - term;
      else      e = e + term;
    end
    for (int i = 0; i <= TAB_N; i++) begin
      num = (Q30 - d) * 64'd65536 + (Q30 + d);
      v = udiv64(num, 64'd2 * (Q30 + d));
      tab[i] = (v > 64'd32767) ? 16'd32767 : v[15:0];
      d = (d * e) >> 30;
    end
    return tab;
  endfunction

  localparam tanh_tab_t TANH_TAB = build_tanh_tab();

endpackage

### hw/rtl/cfsd_ram.sv
// Generic simple dual-port RAM, one write port and one registered read port.
module cfsd_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/cfsd_ring.sv
// Ring buffers, tap addressing, cross-feedback mixing and ring write-back.
module cfsd_ring
  import cfsd_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  ring_cfg_t                     cfg,
  input  logic                          accept,
  input  logic signed [SAMPLE_BITS-1:0] dry_left,
  input  logic signed [SAMPLE_BITS-1:0] dry_right,
  output mix_t                          mix
);

  function automatic logic [ADDR_W-1:0] clamp_off(input logic [CFG_OFF_W-1:0] off,
                                                  input logic [LEN_W-1:0] lim);
    logic [OFF_CMP_W-1:0] o;
    logic [OFF_CMP_W-1:0] m;
    logic [OFF_CMP_W-1:0] r;
    o = OFF_CMP_W'(off);
    m = OFF_CMP_W'(lim);
    if (o == '0)    r = OFF_CMP_W'(1);
    else if (o > m) r = m;
    else            r = o;
    return r[ADDR_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] tap_addr(input logic [ADDR_W-1:0] wpos,
                                                 input logic [ADDR_W-1:0] off,
                                                 input logic [LEN_W-1:0] len);
    logic [LEN_W:0] t;
    if (wpos >= off) t = (LEN_W+1)'(wpos) - (LEN_W+1)'(off);
    else             t = (LEN_W+1)'(wpos) + (LEN_W+1)'(len) - (LEN_W+1)'(off);
    return t[ADDR_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] gain(
      input logic signed [SAMPLE_BITS-1:0] x, input logic signed [GAIN_W-1:0] c);
    logic signed [PROD_W-1:0] xe;
    logic signed [PROD_W-1:0] ce;
    logic signed [PROD_W-1:0] p;
    xe = x;
    ce = c;
    p = xe * ce + GAIN_ROUND;
    p = p >>> GAIN_SHIFT;
    return p[SAMPLE_BITS-1:0];
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] add_sat(
      input logic signed [SAMPLE_BITS-1:0] a, input logic signed [SAMPLE_BITS-1:0] b);
    logic signed [SAMPLE_BITS:0] ae;
    logic signed [SAMPLE_BITS:0] be;
    logic signed [SAMPLE_BITS:0] s;
    ae = a;
    be = b;
    s = ae + be;
    if (s[SAMPLE_BITS] != s[SAMPLE_BITS-1]) return s[SAMPLE_BITS] ? SAMPLE_MIN : SAMPLE_MAX;
    return s[SAMPLE_BITS-1:0];
  endfunction

  logic [ADDR_W-1:0] wp;
  logic [ADDR_W-1:0] wp_next;
  logic [LEN_W-1:0]  fill;
  logic [LEN_W-1:0]  fill_next;

  logic [CLEN_W-1:0] len_wide;
  logic [CLEN_W-1:0] len_clamped;
  logic [LEN_W-1:0]  len_eff;
  logic [ADDR_W-1:0] off_l;
  logic [ADDR_W-1:0] off_r;
  logic [ADDR_W-1:0] wp_eff;
  logic [LEN_W-1:0]  wp_inc;
  logic [ADDR_W-1:0] raddr_l;
  logic [ADDR_W-1:0] raddr_r;

  logic                          s1_valid;
  logic [ADDR_W-1:0]             s1_waddr;
  logic signed [SAMPLE_BITS-1:0] s1_dl;
  logic signed [SAMPLE_BITS-1:0] s1_dr;
  logic                          s1_fwd_l;
  logic                          s1_fwd_r;
  logic                          s1_hit_l;
  logic                          s1_hit_r;

  logic signed [SAMPLE_BITS-1:0] rd_l;
  logic signed [SAMPLE_BITS-1:0] rd_r;
  logic signed [SAMPLE_BITS-1:0] wq_l;
  logic signed [SAMPLE_BITS-1:0] wq_r;
  logic signed [SAMPLE_BITS-1:0] tap_l;
  logic signed [SAMPLE_BITS-1:0] tap_r;
  logic signed [SAMPLE_BITS-1:0] wr_l;
  logic signed [SAMPLE_BITS-1:0] wr_r;
  logic signed [SAMPLE_BITS-1:0] ml;
  logic signed [SAMPLE_BITS-1:0] mr;

  logic                          mix_valid;
  logic signed [SAMPLE_BITS-1:0] mix_left;
  logic signed [SAMPLE_BITS-1:0] mix_right;

  // address stage
  always_comb begin
    len_wide = CLEN_W'(cfg.ring_length);
    if (len_wide < CLEN_W'(2))               len_clamped = CLEN_W'(2);
    else if (len_wide > CLEN_W'(RING_DEPTH)) len_clamped = CLEN_W'(RING_DEPTH);
    else                                     len_clamped = len_wide;
    len_eff = len_clamped[LEN_W-1:0];
    off_l = clamp_off(cfg.left_tap_offset, len_eff - LEN_W'(1));
    off_r = clamp_off(cfg.right_tap_offset, len_eff - LEN_W'(1));
    wp_eff = (LEN_W'(wp) >= len_eff) ? '0 : wp;
    raddr_l = tap_addr(wp_eff, off_l, len_eff);
    raddr_r = tap_addr(wp_eff, off_r, len_eff);
    wp_inc = LEN_W'(wp_eff) + LEN_W'(1);
    wp_next = (wp_inc >= len_eff) ? '0 : wp_inc[ADDR_W-1:0];
    // entries at or above the fill mark were never written and read as zero
    fill_next = (wp_inc > fill) ? wp_inc : fill;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      fill <= '0;
      s1_valid <= 1'b0;
      mix_valid <= 1'b0;
    end else begin
      if (accept) begin
        wp <= wp_next;
        fill <= fill_next;
      end
      s1_valid <= accept;
      mix_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_waddr <= wp_eff;
    s1_dl <= dry_left;
    s1_dr <= dry_right;
    // previous item writes this entry in the same cycle as the read
    s1_fwd_l <= s1_valid && (raddr_l == s1_waddr);
    s1_fwd_r <= s1_valid && (raddr_r == s1_waddr);
    s1_hit_l <= LEN_W'(raddr_l) < fill;
    s1_hit_r <= LEN_W'(raddr_r) < fill;
    wq_l <= wr_l;
    wq_r <= wr_r;
    mix_left <= ml;
    mix_right <= mr;
  end

  // mix and write-back stage
  always_comb begin
    tap_l = s1_fwd_l ? wq_l : (s1_hit_l ? rd_l : '0);
    tap_r = s1_fwd_r ? wq_r : (s1_hit_r ? rd_r : '0);
    ml = add_sat(s1_dl, gain(tap_r, GAIN_OUT));
    mr = add_sat(s1_dr, gain(tap_l, GAIN_OUT));
    wr_l = add_sat(s1_dl, gain(tap_r, GAIN_FB));
    wr_r = add_sat(s1_dr, gain(tap_l, GAIN_FB));
  end

  cfsd_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(RING_DEPTH)
  ) u_left_ring (
    .clk  (clk),
    .we   (s1_valid),
    .waddr(s1_waddr),
    .wdata(wr_l),
    .raddr(raddr_l),
    .rdata(rd_l)
  );

  cfsd_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(RING_DEPTH)
  ) u_right_ring (
    .clk  (clk),
    .we   (s1_valid),
    .waddr(s1_waddr),
    .wdata(wr_r),
    .raddr(raddr_r),
    .rdata(rd_r)
  );

  assign mix.valid = mix_valid;
  assign mix.left  = mix_left;
  assign mix.right = mix_right;

endmodule

### hw/rtl/cfsd_shaper.sv
// Two-lane tanh saturator: table lookup with linear interpolation.
module cfsd_shaper
  import cfsd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  mix_t mix,
  output logic push,
  output wet_t wet
);

  logic signed [SAMPLE_BITS-1:0] lane_in [2];
  logic [OUT_W-1:0]              lane_out [2];
  logic                          s3_valid;

  assign lane_in[0] = mix.left;
  assign lane_in[1] = mix.right;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= mix.valid;
    end
  end

  for (genvar c = 0; c < 2; c++) begin : g_lane
    logic signed [ABS_W:0]       s_ext;
    logic signed [ABS_W:0]       mag;
    logic [ABS_W-1:0]            a;
    logic                        over;
    logic [TAB_IDX_W-1:0]        idx_lo;
    logic [TAB_IDX_W-1:0]        idx_hi;
    logic [TAB_SH-1:0]           frac;
    logic [OUT_W-1:0]            lo;
    logic [OUT_W-1:0]            hi;
    logic [TAB_SH-1:0]           frac_q;
    logic                        neg_q;
    logic [OUT_W-1:0]            diff;
    logic [OUT_W+TAB_SH-1:0]     prod;
    logic [OUT_W-1:0]            mag_out;

    always_comb begin
      s_ext = lane_in[c];
      mag = s_ext[ABS_W] ? -s_ext : s_ext;
      a = mag[ABS_W-1:0];
      over = {1'b0, a} >= (ABS_W+1)'(TAB_SPAN);
      if (over) begin
        idx_lo = TAB_IDX_W'(TAB_N);
        idx_hi = TAB_IDX_W'(TAB_N);
        frac = '0;
      end else begin
        idx_lo = TAB_IDX_W'(a[TAB_SPAN_BITS-1:TAB_SH]);
        idx_hi = idx_lo + TAB_IDX_W'(1);
        frac = a[TAB_SH-1:0];
      end
    end

    always_ff @(posedge clk) begin
      lo <= TANH_TAB[idx_lo];
      hi <= TANH_TAB[idx_hi];
      frac_q <= frac;
      neg_q <= s_ext[ABS_W];
    end

    always_comb begin
      diff = hi - lo;
      prod = (OUT_W+TAB_SH)'(diff) * (OUT_W+TAB_SH)'(frac_q) + (OUT_W+TAB_SH)'(TAB_HALF);
      mag_out = lo + prod[OUT_W+TAB_SH-1:TAB_SH];
    end

    assign lane_out[c] = neg_q ? -mag_out : mag_out;
  end

  assign push      = s3_valid;
  assign wet.left  = lane_out[0];
  assign wet.right = lane_out[1];

endmodule

### hw/rtl/cfsd_fifo.sv
// Output queue holding finished results until the downstream side takes them.
module cfsd_fifo
  import cfsd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  wet_t               push_data,
  input  logic               pop,
  output wet_t               head,
  output logic               not_empty,
  output logic [FIFO_CW-1:0] count
);

  wet_t               entries [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      case ({push, pop})
        2'b10: count <= count + FIFO_CW'(1);
        2'b01: count <= count - FIFO_CW'(1);
        default: count <= count;
      endcase
    end
  end

  assign head      = entries[rd_ptr];
  assign not_empty = count != '0;

endmodule

### hw/rtl/cross_feedback_stereo_delay_unit.sv
// Top level of the cross-feedback stereo delay with tanh output saturation.
// Takes one stereo Q3.15 pair per clock while the output queue has room and
// returns one Q1.15 pair per pair taken, in order. With the output side always
// ready each result passes the ring, mix, table and queue registers. Throughput
// is set by the two ring RAMs, each doing one tap read and one write-back per
// sample. Both rings live in simple dual-port RAMs with registered read; a fill
// mark makes never-written entries read as zero, so there is no clearing pass
// after reset. A tap that hits the entry written by the previous sample is
// forwarded. An eight-entry output queue absorbs downstream stalls and input
// ready drops once it nears full. Configuration writes are taken at any time but
// must only be issued while the block is idle.
module cross_feedback_stereo_delay_unit
  import cfsd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // dry_left, dry_right, zero pad
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata    // wet_left, wet_right
);

  ring_cfg_t          cfg;
  logic               accept;
  mix_t               mix;
  logic               push;
  wet_t               wet;
  wet_t               head;
  logic               not_empty;
  logic [FIFO_CW-1:0] count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ring_length <= RING_LENGTH_RESET;
      cfg.left_tap_offset <= LEFT_TAP_OFFSET_RESET;
      cfg.right_tap_offset <= RIGHT_TAP_OFFSET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_RING_LENGTH: begin
          cfg.ring_length <= cfg_data[CFG_LEN_W-1:0];
        end
        REG_LEFT_TAP_OFFSET: begin
          cfg.left_tap_offset <= cfg_data[CFG_OFF_W-1:0];
        end
        REG_RIGHT_TAP_OFFSET: begin
          cfg.right_tap_offset <= cfg_data[CFG_OFF_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // leave room in the queue for everything still in the pipeline
  assign s_axis_tready = count <= FIFO_CW'(FIFO_DEPTH - IN_FLIGHT - 1);
  assign accept = s_axis_tvalid && s_axis_tready;

  cfsd_ring u_ring (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .accept   (accept),
    .dry_left (s_axis_tdata[SAMPLE_BITS-1:0]),
    .dry_right(s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .mix      (mix)
  );

  cfsd_shaper u_shaper (
    .clk (clk),
    .rst (rst),
    .mix (mix),
    .push(push),
    .wet (wet)
  );

  cfsd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(wet),
    .pop      (m_axis_tvalid && m_axis_tready),
    .head     (head),
    .not_empty(not_empty),
    .count    (count)
  );

  assign m_axis_tvalid = not_empty;
  assign m_axis_tdata  = OUT_DATA_W'(head);

endmodule
